// ----- hdl/evfg_pkg.sv -----
// Shared types, codes and sizes for the event flag group block.
// No dependencies; imported by evfg_ram users and the top level.
package evfg_pkg;

    localparam int WAITER_SLOTS = 16;
    localparam int IDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int CNT_W = $clog2(WAITER_SLOTS + 1);

    localparam int FLAG_W   = 32;
    localparam int TID_W    = 4;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_WAIT  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WOKEN  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SAT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_QUEUED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

    typedef logic [FLAG_W-1:0]   t_flags;
    typedef logic [TID_W-1:0]    t_tid;
    typedef logic [STATUS_W-1:0] t_status;

    typedef struct packed {
        t_tid   thread;
        t_flags mask;
        logic   mode_all;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic cond_holds(t_flags flags, t_flags mask, logic all);
        if (all) begin
            return (flags & mask) == mask;
        end
        return (flags & mask) != '0;
    endfunction

endpackage

// ----- hdl/evfg_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module evfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/event_flag_group_waiter_wake.sv -----
// Event flag group with an arrival-ordered waiter table.
// Depends on evfg_pkg and evfg_ram.
//
// Usage
//   Request channel: drive i_opcode, i_flag_mask, i_thread_id, i_wait_all
//   and raise start; the request is taken at a clock edge where start is
//   high and busy is low.
//   Result channel: each result sits on the o_ ports for one cycle with
//   o_valid high. o_last_result marks the final result of a request. The
//   receiver cannot stall, so results are simply presented once.
// Latency / throughput
//   Clear, wait, unknown opcodes and a set with an empty table: one result
//   in the cycle after the request; busy stays low, so a request can be
//   taken every cycle.
//   Set with N queued waiters: the table memory is read one entry per cycle
//   (one read port, registered read) and survivors are written back
//   compacted in place. busy stays high while the table is walked and the
//   final result is formed, so no new request is taken meanwhile.
// Reset
//   i_rst_n low clears the flag word, the waiter count and the control
//   state. The table memory is not cleared; entries past the count are
//   never read.
module event_flag_group_waiter_wake (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [evfg_pkg::OP_W-1:0] i_opcode,
    input  evfg_pkg::t_flags          i_flag_mask,
    input  evfg_pkg::t_tid            i_thread_id,
    input  logic                      i_wait_all,
    output logic                      o_valid,
    output evfg_pkg::t_status         o_status,
    output evfg_pkg::t_tid            o_woken_thread,
    output evfg_pkg::t_flags          o_flag_value,
    output logic                      o_last_result
);
    import evfg_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    t_flags           r_flag, n_flag;
    logic [CNT_W-1:0] r_count, n_count;

    // walk bookkeeping
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;   // next entry to read
    logic [CNT_W-1:0] r_proc, n_proc;       // entries already examined
    logic [CNT_W-1:0] r_keep, n_keep;       // survivors written back
    logic             r_dv, n_dv;           // read data valid this cycle
    logic             r_pend, n_pend;       // a woken result is held back
    t_tid             r_pend_tid, n_pend_tid;

    // result register
    logic    r_valid, n_valid;
    t_status r_status, n_status;
    t_tid    r_tid, n_tid;
    t_flags  r_fv, n_fv;
    logic    r_last, n_last;

    // table memory
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_rdata;

    evfg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WAITER_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic accept;
    logic hit;
    logic rd_go;
    t_flags set_flags;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign hit    = cond_holds(r_flag, ram_rdata.mask, ram_rdata.mode_all);
    assign rd_go  = (r_rd_idx < r_count);
    assign set_flags = r_flag | i_flag_mask;

    always_comb begin
        n_state    = r_state;
        n_flag     = r_flag;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_proc     = r_proc;
        n_keep     = r_keep;
        n_dv       = 1'b0;
        n_pend     = r_pend;
        n_pend_tid = r_pend_tid;

        n_valid  = 1'b0;
        n_status = r_status;
        n_tid    = r_tid;
        n_fv     = r_fv;
        n_last   = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = r_count[IDX_W-1:0];
        ram_wdata = '{thread: i_thread_id, mask: i_flag_mask, mode_all: i_wait_all};
        ram_raddr = r_rd_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    n_last  = 1'b1;
                    n_tid   = i_thread_id;
                    n_fv    = r_flag;
                    case (i_opcode)
                        OP_SET: begin
                            n_flag   = set_flags;
                            n_fv     = set_flags;
                            n_status = ST_DONE;
                            n_tid    = '0;
                            if (r_count != '0) begin
                                // results come from the walk instead
                                n_valid  = 1'b0;
                                n_last   = 1'b0;
                                n_state  = S_WALK;
                                n_rd_idx = '0;
                                n_proc   = '0;
                                n_keep   = '0;
                                n_pend   = 1'b0;
                            end
                        end
                        OP_CLEAR: begin
                            n_flag   = r_flag & ~i_flag_mask;
                            n_fv     = r_flag & ~i_flag_mask;
                            n_status = ST_DONE;
                            n_tid    = '0;
                        end
                        OP_WAIT: begin
                            if (cond_holds(r_flag, i_flag_mask, i_wait_all)) begin
                                n_status = ST_SAT;
                            end else if (r_count < CNT_W'(WAITER_SLOTS)) begin
                                ram_we   = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                                n_status = ST_QUEUED;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        default: begin
                            n_status = ST_DONE;
                            n_tid    = '0;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // issue one read per cycle
                if (rd_go) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                    n_dv     = 1'b1;
                end
                // examine the entry read last cycle
                if (r_dv) begin
                    n_proc = r_proc + CNT_W'(1);
                    if (hit) begin
                        // hold each wake one step so the final one gets last
                        if (r_pend) begin
                            n_valid  = 1'b1;
                            n_status = ST_WOKEN;
                            n_tid    = r_pend_tid;
                            n_fv     = r_flag;
                        end
                        n_pend     = 1'b1;
                        n_pend_tid = ram_rdata.thread;
                    end else begin
                        // compact survivor; keep never passes the read pointer
                        ram_we    = 1'b1;
                        ram_waddr = r_keep[IDX_W-1:0];
                        ram_wdata = ram_rdata;
                        n_keep    = r_keep + CNT_W'(1);
                    end
                    if (r_proc + CNT_W'(1) == r_count) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                n_valid  = 1'b1;
                n_last   = 1'b1;
                n_fv     = r_flag;
                n_status = r_pend ? ST_WOKEN : ST_DONE;
                n_tid    = r_pend ? r_pend_tid : '0;
                n_pend   = 1'b0;
                n_count  = r_keep;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flag  <= '0;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flag  <= n_flag;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    // payload and walk pointers, no reset needed
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_proc     <= n_proc;
        r_keep     <= n_keep;
        r_pend_tid <= n_pend_tid;
        r_status   <= n_status;
        r_tid      <= n_tid;
        r_fv       <= n_fv;
        r_last     <= n_last;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_woken_thread = r_tid;
    assign o_flag_value   = r_fv;
    assign o_last_result  = r_valid && r_last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WAITER_SLOTS))
        else $error("waiter count above table size");

    a_keep_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_keep <= r_proc && r_proc <= r_rd_idx))
        else $error("compaction pointer ahead of read pointer");

    a_dv_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_WALK))
        else $error("table read data outside walk");

    a_fin_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (o_valid && o_last_result && !busy))
        else $error("set walk did not end with a final result");

    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode != OP_SET) |=> (o_valid && o_last_result))
        else $error("single-result request missing its result");
`endif

endmodule
